// ===== rtl/luhn_pkg.sv =====
// ----------------------------------------------------------------------------
// luhn_pkg
// shared widths, verdict codes and digit helpers for the luhn checker
// ----------------------------------------------------------------------------
package luhn_pkg;

   localparam int CARD_W     = 54;
   localparam int NUM_DIGITS = 17;
   localparam int BCD_W      = NUM_DIGITS * 4;
   localparam int MAX_DIGITS = 16;
   localparam int COUNT_W    = 5;
   localparam int GRP_SIZE   = 4;
   localparam int NUM_GRP    = (NUM_DIGITS + GRP_SIZE - 1) / GRP_SIZE;

   typedef enum logic [1:0] {
      VERDICT_INVALID    = 2'd0,
      VERDICT_AMEX       = 2'd1,
      VERDICT_VISA       = 2'd2,
      VERDICT_MASTERCARD = 2'd3
   } verdict_type;

   typedef logic [BCD_W-1:0] bcd_type;

   // add 3 to every digit of 5 or more
   function automatic bcd_type bcd_adjust(input bcd_type b);
      bcd_type r;
      r = b;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (b[i*4 +: 4] >= 4'd5) begin
            r[i*4 +: 4] = b[i*4 +: 4] + 4'd3;
         end
      end
      return r;
   endfunction

   // digit sum of twice a decimal digit
   function automatic logic [4:0] doubled_sum(input logic [3:0] d);
      logic [4:0] p;
      p = {d, 1'b0};
      if (d >= 4'd5) begin
         p = p - 5'd9;
      end
      return p;
   endfunction

endpackage

// ===== rtl/luhn_b2d.sv =====
// ----------------------------------------------------------------------------
// luhn_b2d
// pipelined binary to decimal conversion, one input bit per stage
// ----------------------------------------------------------------------------
module luhn_b2d (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [luhn_pkg::CARD_W-1:0]   in_bin,
   output logic                          out_valid,
   output logic [luhn_pkg::BCD_W-1:0]    out_bcd
);
   import luhn_pkg::*;

   logic              vld_ff [0:CARD_W-1];
   bcd_type           bcd_ff [0:CARD_W-1];
   logic [CARD_W-1:0] bin_ff [0:CARD_W-1];

   for (genvar g = 0; g < CARD_W; g++) begin : g_stage
      logic              vld_in;
      bcd_type           bcd_src;
      logic [CARD_W-1:0] bin_src;
      bcd_type           adj;

      if (g == 0) begin : g_first
         assign vld_in  = in_valid;
         assign bcd_src = '0;
         assign bin_src = in_bin;
      end else begin : g_next
         assign vld_in  = vld_ff[g-1];
         assign bcd_src = bcd_ff[g-1];
         assign bin_src = bin_ff[g-1];
      end

      assign adj = bcd_adjust(bcd_src);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (advance) begin
            vld_ff[g] <= vld_in;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            bcd_ff[g] <= {adj[BCD_W-2:0], bin_src[CARD_W-1]};
            bin_ff[g] <= {bin_src[CARD_W-2:0], 1'b0};
         end
      end
   end

   assign out_valid = vld_ff[CARD_W-1];
   assign out_bcd   = bcd_ff[CARD_W-1];

endmodule

// ===== rtl/luhn_card_number_checker_core.sv =====
// ----------------------------------------------------------------------------
// luhn_card_number_checker_core
// luhn checksum, digit count and network verdict for a binary card number
// ----------------------------------------------------------------------------
// Takes one transaction per clock while req_stall is low and returns one result
// per transaction, in order: the one-bit-per-stage binary to decimal pipeline,
// then a stage forming digit count, leading digits and partial luhn sums, and
// a stage for the final sum, mod-ten test and verdict. A stall on the result
// side freezes the whole pipeline.
module luhn_card_number_checker_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [luhn_pkg::CARD_W-1:0]   req_card_number,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_verdict,
   output logic                          rsp_luhn_ok,
   output logic [luhn_pkg::COUNT_W-1:0]  rsp_digit_count
);
   import luhn_pkg::*;

   logic    advance;
   logic    b2d_valid;
   bcd_type b2d_bcd;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   luhn_b2d u_b2d (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_bin    (req_card_number),
      .out_valid (b2d_valid),
      .out_bcd   (b2d_bcd)
   );

   // digit count, leading digits, grouped luhn sums
   logic               s1_vld_ff;
   logic [COUNT_W-1:0] s1_count_ff, s1_count_in;
   logic [3:0]         s1_hi_ff, s1_hi_in, s1_lo_ff, s1_lo_in;
   logic [5:0]         s1_grp_ff [0:NUM_GRP-1];
   logic [5:0]         s1_grp_in [0:NUM_GRP-1];

   always_comb begin
      s1_count_in = '0;
      s1_hi_in    = '0;
      s1_lo_in    = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (b2d_bcd[i*4 +: 4] != 4'd0) begin
            s1_count_in = COUNT_W'(i + 1);
            s1_hi_in    = b2d_bcd[i*4 +: 4];
            s1_lo_in    = (i > 0) ? b2d_bcd[((i > 0) ? i - 1 : 0)*4 +: 4] : 4'd0;
         end
      end
      for (int g = 0; g < NUM_GRP; g++) begin
         s1_grp_in[g] = '0;
         for (int k = 0; k < GRP_SIZE; k++) begin
            if (g * GRP_SIZE + k < NUM_DIGITS) begin
               if (((g * GRP_SIZE + k) % 2) == 0) begin
                  s1_grp_in[g] = s1_grp_in[g]
                     + 6'(b2d_bcd[((g * GRP_SIZE + k) % NUM_DIGITS)*4 +: 4]);
               end else begin
                  s1_grp_in[g] = s1_grp_in[g]
                     + 6'(doubled_sum(b2d_bcd[((g * GRP_SIZE + k) % NUM_DIGITS)*4 +: 4]));
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= b2d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_count_ff <= s1_count_in;
         s1_hi_ff    <= s1_hi_in;
         s1_lo_ff    <= s1_lo_in;
         for (int g = 0; g < NUM_GRP; g++) begin
            s1_grp_ff[g] <= s1_grp_in[g];
         end
      end
   end

   // total, mod ten, verdict
   logic [7:0]         total;
   logic [15:0]        quot_full;
   logic [4:0]         quot;
   logic               luhn_in;
   verdict_type        verdict_in;
   logic               rsp_valid_ff;
   logic               rsp_luhn_ok_ff;
   logic [1:0]         rsp_verdict_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   always_comb begin
      total = '0;
      for (int g = 0; g < NUM_GRP; g++) begin
         total = total + 8'(s1_grp_ff[g]);
      end
      quot_full  = 16'(total) * 16'd205;
      quot       = quot_full[15:11];
      luhn_in    = (total == 8'({quot, 3'b000} + {quot, 1'b0}));
      verdict_in = VERDICT_INVALID;
      if (luhn_in && s1_count_ff <= COUNT_W'(MAX_DIGITS)) begin
         priority if (s1_count_ff == 5'd15) begin
            if (s1_hi_ff == 4'd3 && (s1_lo_ff == 4'd4 || s1_lo_ff == 4'd7)) begin
               verdict_in = VERDICT_AMEX;
            end
         end else if (s1_count_ff == 5'd13) begin
            if (s1_hi_ff == 4'd4) begin
               verdict_in = VERDICT_VISA;
            end
         end else if (s1_count_ff == 5'd16) begin
            if (s1_hi_ff == 4'd5 && s1_lo_ff >= 4'd1 && s1_lo_ff <= 4'd5) begin
               verdict_in = VERDICT_MASTERCARD;
            end else if (s1_hi_ff == 4'd4) begin
               verdict_in = VERDICT_VISA;
            end
         end else begin
            verdict_in = VERDICT_INVALID;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_luhn_ok_ff <= luhn_in;
         rsp_verdict_ff <= verdict_in;
         rsp_count_ff   <= s1_count_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_luhn_ok     = rsp_luhn_ok_ff;
   assign rsp_verdict     = rsp_verdict_ff;
   assign rsp_digit_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_verdict_needs_luhn : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict != VERDICT_INVALID |-> rsp_luhn_ok)
      else $error("verdict without luhn pass");
   a_amex_length : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == VERDICT_AMEX |-> rsp_digit_count == 5'd15)
      else $error("amex verdict with wrong length");
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_digit_count <= 5'(NUM_DIGITS))
      else $error("digit count out of range");
   a_stall_freezes : assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && req_stall |=> s1_vld_ff)
      else $error("pipeline moved under stall");
`endif

endmodule
